// File: rtl/sgdm_pkg.sv
// sgdm_pkg: shared constants, register indexes and helpers for the sgd momentum unit
// no dependencies; used by the coefficient multiplier, the top level and the bench
package sgdm_pkg;

  // coefficients are unsigned Q0.16, one extra bit so that 1.0 fits
  localparam int COEF_BITS = 16;
  localparam int COEF_W    = COEF_BITS + 1;

  typedef logic [COEF_W-1:0] coef_t;

  localparam coef_t COEF_ONE = coef_t'(1) << COEF_BITS;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = COEF_W;

  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [CFG_DATA_W-1:0] cfg_data_t;

  // register indexes
  localparam cfg_idx_t REG_LEARNING_RATE = cfg_idx_t'(0);
  localparam cfg_idx_t REG_MOMENTUM      = cfg_idx_t'(1);
  localparam cfg_idx_t REG_DAMPENING     = cfg_idx_t'(2);
  localparam cfg_idx_t REG_DECAY         = cfg_idx_t'(3);
  localparam cfg_idx_t REG_NESTEROV      = cfg_idx_t'(4);

  // register reset values
  localparam coef_t LR_RESET        = coef_t'(655);
  localparam coef_t MOMENTUM_RESET  = coef_t'(0);
  localparam coef_t DAMPENING_RESET = coef_t'(0);
  localparam coef_t DECAY_RESET     = coef_t'(0);

  // anything above 1.0 acts as 1.0
  function automatic coef_t clamp_coef(input coef_t c);
    clamp_coef = (c > COEF_ONE) ? COEF_ONE : c;
  endfunction

endpackage

// File: rtl/sgdm_in_if.sv
// sgdm_in_if: input channel, one weight, gradient and buffer element per transfer
// depends on nothing; valid/ready handshake
interface sgdm_in_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] weight_in;
  logic signed [VALUE_WIDTH-1:0] gradient_in;
  logic signed [VALUE_WIDTH-1:0] velocity_in;

  modport source (output valid, output weight_in, output gradient_in, output velocity_in,
                  input ready);
  modport sink   (input valid, input weight_in, input gradient_in, input velocity_in,
                  output ready);
endinterface

// File: rtl/sgdm_out_if.sv
// sgdm_out_if: result channel, updated weight and buffer element per transfer
// depends on nothing; valid/ready handshake
interface sgdm_out_if #(
  parameter int VALUE_WIDTH = 32
);
  logic                          valid;
  logic                          ready;
  logic signed [VALUE_WIDTH-1:0] weight_out;
  logic signed [VALUE_WIDTH-1:0] velocity_out;

  modport source (output valid, output weight_out, output velocity_out, input ready);
  modport sink   (input valid, input weight_out, input velocity_out, output ready);
endinterface

// File: rtl/sgdm_coef_mul.sv
// sgdm_coef_mul: registered value times Q0.16 coefficient, rounded half up, saturated
// depends on sgdm_pkg
module sgdm_coef_mul #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                          clk,
  input  logic                          en,
  input  logic signed [VALUE_WIDTH-1:0] val,
  input  sgdm_pkg::coef_t               coef,
  output logic signed [VALUE_WIDTH-1:0] prod
);

  localparam int PW = VALUE_WIDTH + sgdm_pkg::COEF_BITS + 2;
  localparam int SW = PW - sgdm_pkg::COEF_BITS;

  localparam logic signed [PW-1:0] ROUND = PW'(1) << (sgdm_pkg::COEF_BITS - 1);
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic signed [PW-1:0] val_ext;
  logic signed [PW-1:0] coef_ext;
  logic signed [PW-1:0] prod_nxt;
  logic signed [PW-1:0] prod_r;
  logic signed [SW-1:0] shifted;

  // multiply and add the rounding constant
  assign val_ext  = {{(PW-VALUE_WIDTH){val[VALUE_WIDTH-1]}}, val};
  assign coef_ext = {{(PW-sgdm_pkg::COEF_W){1'b0}}, coef};
  assign prod_nxt = PW'(val_ext * coef_ext) + ROUND;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod_nxt;
    end
  end

  // floor shift, then saturate to the value width
  assign shifted = prod_r[PW-1:sgdm_pkg::COEF_BITS];

  always_comb begin
    if (shifted[SW-1:VALUE_WIDTH-1] == '0 || shifted[SW-1:VALUE_WIDTH-1] == '1) begin
      prod = shifted[VALUE_WIDTH-1:0];
    end else if (shifted[SW-1]) begin
      prod = VMIN;
    end else begin
      prod = VMAX;
    end
  end

endmodule

// File: rtl/sgd_momentum_update_unit.sv
// sgd_momentum_update_unit: eight-stage pipeline, one element per cycle sustained while the
// output is ready; each stage holds one coefficient multiply or one saturating add
// or subtract, and stages with a bubble keep taking items while the output is stalled.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register defaults:
// learning rate 655, other coefficients 0, nesterov off.
// depends on sgdm_pkg, sgdm_in_if, sgdm_out_if, sgdm_coef_mul
module sgd_momentum_update_unit #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  sgdm_in_if.sink             in_item,
  sgdm_out_if.source          out_item,
  input  logic                cfg_we,
  input  sgdm_pkg::cfg_idx_t  cfg_idx,
  input  sgdm_pkg::cfg_data_t cfg_wdata
);

  localparam int VW = VALUE_WIDTH;
  localparam int NS = 8;

  localparam logic signed [VW-1:0] VMAX = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW-1:0] VMIN = {1'b1, {(VW-1){1'b0}}};

  // saturating add of two values
  function automatic logic signed [VW-1:0] sat_add(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} + {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      sat_add = s[VW] ? VMIN : VMAX;
    end else begin
      sat_add = s[VW-1:0];
    end
  endfunction

  // saturating subtract a - b
  function automatic logic signed [VW-1:0] sat_sub(input logic signed [VW-1:0] a,
                                                   input logic signed [VW-1:0] b);
    logic signed [VW:0] s;
    s = {a[VW-1], a} - {b[VW-1], b};
    if (s[VW] != s[VW-1]) begin
      sat_sub = s[VW] ? VMIN : VMAX;
    end else begin
      sat_sub = s[VW-1:0];
    end
  endfunction

  // configuration registers
  sgdm_pkg::coef_t lr_r, mu_r, damp_r, wd_r;
  logic            nest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r   <= sgdm_pkg::LR_RESET;
      mu_r   <= sgdm_pkg::MOMENTUM_RESET;
      damp_r <= sgdm_pkg::DAMPENING_RESET;
      wd_r   <= sgdm_pkg::DECAY_RESET;
      nest_r <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        sgdm_pkg::REG_LEARNING_RATE: lr_r   <= cfg_wdata;
        sgdm_pkg::REG_MOMENTUM:      mu_r   <= cfg_wdata;
        sgdm_pkg::REG_DAMPENING:     damp_r <= cfg_wdata;
        sgdm_pkg::REG_DECAY:         wd_r   <= cfg_wdata;
        sgdm_pkg::REG_NESTEROV:      nest_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // effective coefficients
  sgdm_pkg::coef_t lr_c, mu_c, wd_c, keep_c;
  logic            mu_zero;

  assign lr_c    = sgdm_pkg::clamp_coef(lr_r);
  assign mu_c    = sgdm_pkg::clamp_coef(mu_r);
  assign wd_c    = sgdm_pkg::clamp_coef(wd_r);
  assign keep_c  = sgdm_pkg::COEF_ONE - sgdm_pkg::clamp_coef(damp_r);
  assign mu_zero = (mu_c == '0);

  // stage valid bits and per-stage advance; a stage moves when empty or when its successor moves
  logic [NS-1:0] v_r;
  logic [NS-1:0] adv;

  always_comb begin
    adv[NS-1] = !v_r[NS-1] || out_item.ready;
    for (int k = NS - 2; k >= 0; k--) begin
      adv[k] = !v_r[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (adv[0]) begin
        v_r[0] <= in_item.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (adv[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_item.ready = adv[0];

  // stage payload registers
  logic signed [VW-1:0] w0_r, g0_r, b0_r;
  logic signed [VW-1:0] w1_r, g1_r, b1_r;
  logic signed [VW-1:0] w2_r, g2_r, b2_r;
  logic signed [VW-1:0] w3_r, g3_r, b3_r;
  logic signed [VW-1:0] w4_r, g4_r, b4_r;
  logic signed [VW-1:0] w5_r, u5_r, b5_r;
  logic signed [VW-1:0] w6_r, b6_r;
  logic signed [VW-1:0] w7_r, b7_r;

  logic signed [VW-1:0] q_wd, q_mb, q_kg, q_nb, q_lr;
  logic signed [VW-1:0] g1_nxt, b3_nxt, u5_nxt, w7_nxt;

  // stage 0: decay times weight
  sgdm_coef_mul #(.VALUE_WIDTH(VW)) u_mul_decay (
    .clk (clk), .en (adv[0]), .val (in_item.weight_in), .coef (wd_c), .prod (q_wd)
  );

  // stage 2: buffer times momentum, gradient times one minus dampening
  sgdm_coef_mul #(.VALUE_WIDTH(VW)) u_mul_buf (
    .clk (clk), .en (adv[2]), .val (b1_r), .coef (mu_c), .prod (q_mb)
  );

  sgdm_coef_mul #(.VALUE_WIDTH(VW)) u_mul_grad (
    .clk (clk), .en (adv[2]), .val (g1_r), .coef (keep_c), .prod (q_kg)
  );

  // stage 4: nesterov lookahead, momentum times new buffer
  sgdm_coef_mul #(.VALUE_WIDTH(VW)) u_mul_nest (
    .clk (clk), .en (adv[4]), .val (b3_r), .coef (mu_c), .prod (q_nb)
  );

  // stage 6: learning rate times update
  sgdm_coef_mul #(.VALUE_WIDTH(VW)) u_mul_lr (
    .clk (clk), .en (adv[6]), .val (u5_r), .coef (lr_c), .prod (q_lr)
  );

  // add stages
  assign g1_nxt = sat_add(g0_r, q_wd);
  assign b3_nxt = mu_zero ? b2_r : sat_add(q_mb, q_kg);

  always_comb begin
    priority if (mu_zero) begin
      u5_nxt = g4_r;
    end else if (nest_r) begin
      u5_nxt = sat_add(g4_r, q_nb);
    end else begin
      u5_nxt = b4_r;
    end
  end

  assign w7_nxt = sat_sub(w6_r, q_lr);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      w0_r <= in_item.weight_in;
      g0_r <= in_item.gradient_in;
      b0_r <= in_item.velocity_in;
    end
    if (adv[1]) begin
      w1_r <= w0_r;
      g1_r <= g1_nxt;
      b1_r <= b0_r;
    end
    if (adv[2]) begin
      w2_r <= w1_r;
      g2_r <= g1_r;
      b2_r <= b1_r;
    end
    if (adv[3]) begin
      w3_r <= w2_r;
      g3_r <= g2_r;
      b3_r <= b3_nxt;
    end
    if (adv[4]) begin
      w4_r <= w3_r;
      g4_r <= g3_r;
      b4_r <= b3_r;
    end
    if (adv[5]) begin
      w5_r <= w4_r;
      u5_r <= u5_nxt;
      b5_r <= b4_r;
    end
    if (adv[6]) begin
      w6_r <= w5_r;
      b6_r <= b5_r;
    end
    if (adv[7]) begin
      w7_r <= w7_nxt;
      b7_r <= b6_r;
    end
  end

  // result channel
  assign out_item.valid        = v_r[NS-1];
  assign out_item.weight_out   = w7_r;
  assign out_item.velocity_out = b7_r;

endmodule

// File: rtl/sgdm_checker.sv
// sgdm_checker: port-level assertions for sgd_momentum_update_unit, attached by bind
// depends on sgd_momentum_update_unit and its channel interfaces
module sgdm_checker #(
  parameter int VALUE_WIDTH = 32
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_ready,
  input logic                   out_valid,
  input logic                   out_ready,
  input logic [VALUE_WIDTH-1:0] out_weight,
  input logic [VALUE_WIDTH-1:0] out_velocity
);

  // a stalled result holds until its transfer
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_weight) && $stable(out_velocity))
    else $error("stalled result changed");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // whenever the last stage can move, every stage can, so input is taken
  a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled although output is free");

endmodule

bind sgd_momentum_update_unit sgdm_checker #(.VALUE_WIDTH(VALUE_WIDTH)) u_sgdm_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_ready     (in_item.ready),
  .out_valid    (out_item.valid),
  .out_ready    (out_item.ready),
  .out_weight   (out_item.weight_out),
  .out_velocity (out_item.velocity_out)
);

// File: verif/tb_sgd_momentum_update_unit.sv
// tb_sgd_momentum_update_unit: self-checking bench for the sgd momentum update pipeline
// depends on sgdm_pkg, sgdm_in_if, sgdm_out_if and the rtl top level; predicts every
// element update in fixed point and checks each result transfer in order
module tb_sgd_momentum_update_unit;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int     VW               = 32;
  localparam longint VAL_MAX          = (longint'(1) <<< (VW - 1)) - 1;
  localparam longint VAL_MIN          = -VAL_MAX - 1;
  localparam int     RANDOM_PER_PHASE = 150;
  localparam int     DRAIN_CYCLES     = 16;

  typedef struct packed {
    logic [VW-1:0] weight;
    logic [VW-1:0] gradient;
    logic [VW-1:0] velocity;
  } elem_t;

  typedef struct packed {
    logic [VW-1:0] weight;
    logic [VW-1:0] velocity;
  } update_t;

  logic                clk = 1'b0;
  logic                rst_n;
  logic                cfg_we;
  sgdm_pkg::cfg_idx_t  cfg_idx;
  sgdm_pkg::cfg_data_t cfg_wdata;

  sgdm_in_if  #(.VALUE_WIDTH(VW)) in_ch ();
  sgdm_out_if #(.VALUE_WIDTH(VW)) out_ch ();

  sgd_momentum_update_unit #(.VALUE_WIDTH(VW)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_ch),
    .out_item  (out_ch),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata)
  );

  // mirror of the coefficient registers
  sgdm_pkg::coef_t lr_cfg;
  sgdm_pkg::coef_t mu_cfg;
  sgdm_pkg::coef_t damp_cfg;
  sgdm_pkg::coef_t decay_cfg;
  logic            nesterov_cfg;

  elem_t   pending_elems[$];
  update_t expected_updates[$];

  bit steady_run = 1'b0;
  int elems_sent = 0;
  int updates_checked = 0;
  int settings_applied = 0;
  int mismatches = 0;

  // corner elements: weight, gradient, velocity
  logic [VW-1:0] corner_set [0:11][0:2] = '{
    '{32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF},
    '{32'h80000000, 32'h80000000, 32'h80000000},
    '{32'h00000000, 32'h00000000, 32'h00000000},
    '{32'hFFFFFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF},
    '{32'h00000001, 32'h00000001, 32'h00000001},
    '{32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF},
    '{32'h80000000, 32'h7FFFFFFF, 32'h80000000},
    '{32'h00008000, 32'hFFFF8000, 32'h00008000},
    '{32'hFFFF8000, 32'h00007FFF, 32'hFFFF7FFF},
    '{32'h00010000, 32'hFFFF0000, 32'h00020000},
    '{32'h00000001, 32'hFFFFFFFF, 32'h7FFF0000},
    '{32'h80010000, 32'h7FFFFFFF, 32'hFFFFFFFE}
  };

  // lr, momentum, dampening, decay, nesterov for the fixed settings
  sgdm_pkg::cfg_data_t phase_cfg [0:6][0:4] = '{
    '{17'd65536,  17'd65536,  17'd0,      17'd65536,  17'd1},
    '{17'd131071, 17'd131071, 17'd131071, 17'd131071, 17'd1},
    '{17'd0,      17'd0,      17'd0,      17'd0,      17'd0},
    '{17'd655,    17'd58982,  17'd0,      17'd655,    17'd0},
    '{17'd655,    17'd58982,  17'd6554,   17'd0,      17'd1},
    '{17'd65536,  17'd0,      17'd65536,  17'd65536,  17'd1},
    '{17'd1,      17'd1,      17'd65535,  17'd1,      17'd0}
  };

  // clock, 4 ns period
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint clip_value(longint v);
    if (v > VAL_MAX) return VAL_MAX;
    if (v < VAL_MIN) return VAL_MIN;
    return v;
  endfunction

  function automatic sgdm_pkg::coef_t limit_coef(sgdm_pkg::coef_t c);
    return (c > sgdm_pkg::COEF_ONE) ? sgdm_pkg::COEF_ONE : c;
  endfunction

  // value times Q0.16 coefficient, rounded half up, then saturated
  function automatic longint scale_by(longint v, sgdm_pkg::coef_t c);
    longint p;
    p = v * longint'(c) + (longint'(1) <<< (sgdm_pkg::COEF_BITS - 1));
    return clip_value(p >>> sgdm_pkg::COEF_BITS);
  endfunction

  function automatic update_t predict_update(elem_t e);
    longint          w;
    longint          g;
    longint          b;
    longint          step;
    sgdm_pkg::coef_t mu;
    update_t         r;
    w  = longint'($signed(e.weight));
    g  = longint'($signed(e.gradient));
    b  = longint'($signed(e.velocity));
    mu = limit_coef(mu_cfg);
    g  = clip_value(g + scale_by(w, limit_coef(decay_cfg)));
    step = g;
    // buffer only moves with nonzero momentum
    if (mu != '0) begin
      b = clip_value(scale_by(b, mu) +
                     scale_by(g, sgdm_pkg::COEF_ONE - limit_coef(damp_cfg)));
      step = nesterov_cfg ? clip_value(g + scale_by(b, mu)) : b;
    end
    r.weight   = VW'(clip_value(w - scale_by(step, limit_coef(lr_cfg))));
    r.velocity = VW'(b);
    return r;
  endfunction

  function automatic bit take_break();
    return !steady_run && ($urandom_range(0, 99) < 11);
  endfunction

  // mix of full-range, small, corner and near-saturation values
  function automatic logic [VW-1:0] pick_value();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      4, 5, 6: return VW'(int'($urandom_range(0, 1 << 21)) - (1 << 20));
      7: begin
        case ($urandom_range(0, 4))
          0: return VW'(VAL_MAX);
          1: return VW'(VAL_MIN);
          2: return '0;
          3: return '1;
          default: return VW'(1);
        endcase
      end
      8: return VW'(VAL_MAX - longint'($urandom_range(0, 65536)));
      9: return VW'(VAL_MIN + longint'($urandom_range(0, 65536)));
      default: return VW'($urandom);
    endcase
  endfunction

  function automatic sgdm_pkg::cfg_data_t pick_coef();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return sgdm_pkg::COEF_ONE;
      2: return sgdm_pkg::COEF_ONE + sgdm_pkg::cfg_data_t'($urandom_range(1, 65535));
      default: return sgdm_pkg::cfg_data_t'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic void note_error(string msg);
    if (mismatches < 10) $display("mismatch: %s", msg);
    mismatches++;
  endfunction

  task automatic write_reg(sgdm_pkg::cfg_idx_t idx, sgdm_pkg::cfg_data_t data);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= data;
    case (idx)
      sgdm_pkg::REG_LEARNING_RATE: lr_cfg       = data;
      sgdm_pkg::REG_MOMENTUM:      mu_cfg       = data;
      sgdm_pkg::REG_DAMPENING:     damp_cfg     = data;
      sgdm_pkg::REG_DECAY:         decay_cfg    = data;
      sgdm_pkg::REG_NESTEROV:      nesterov_cfg = data[0];
      default: ;
    endcase
  endtask

  // all five registers, then the unmapped indexes, which must be ignored
  task automatic apply_settings(sgdm_pkg::cfg_data_t lr, sgdm_pkg::cfg_data_t mu,
                                sgdm_pkg::cfg_data_t damp, sgdm_pkg::cfg_data_t wd,
                                sgdm_pkg::cfg_data_t nest);
    write_reg(sgdm_pkg::REG_LEARNING_RATE, lr);
    write_reg(sgdm_pkg::REG_MOMENTUM, mu);
    write_reg(sgdm_pkg::REG_DAMPENING, damp);
    write_reg(sgdm_pkg::REG_DECAY, wd);
    write_reg(sgdm_pkg::REG_NESTEROV,
              sgdm_pkg::cfg_data_t'({$urandom_range(0, 65535), nest[0]}));
    for (int i = sgdm_pkg::REG_NESTEROV + 1; i < (1 << sgdm_pkg::CFG_IDX_W); i++) begin
      write_reg(sgdm_pkg::cfg_idx_t'(i), sgdm_pkg::cfg_data_t'($urandom));
    end
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_applied++;
  endtask

  task automatic queue_corners();
    for (int i = 0; i < 12; i++) begin
      pending_elems.push_back({corner_set[i][0], corner_set[i][1], corner_set[i][2]});
    end
  endtask

  task automatic queue_random(int count);
    elem_t e;
    for (int i = 0; i < count; i++) begin
      e.weight   = pick_value();
      e.gradient = pick_value();
      e.velocity = pick_value();
      pending_elems.push_back(e);
    end
  endtask

  task automatic wait_idle();
    while (pending_elems.size() != 0 || in_ch.valid || expected_updates.size() != 0)
      @(posedge clk);
  endtask

  // input driver: predict on each accepted transfer, then offer the next element
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_updates.push_back(predict_update({in_ch.weight_in, in_ch.gradient_in,
                                                   in_ch.velocity_in}));
        elems_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_elems.size() != 0 && !take_break()) begin
          elem_t e;
          e = pending_elems.pop_front();
          in_ch.valid       <= 1'b1;
          in_ch.weight_in   <= e.weight;
          in_ch.gradient_in <= e.gradient;
          in_ch.velocity_in <= e.velocity;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor: compare each transfer with the oldest prediction
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_updates.size() == 0) begin
          note_error($sformatf("unexpected result weight %h velocity %h",
                               out_ch.weight_out, out_ch.velocity_out));
        end else begin
          update_t exp_upd;
          exp_upd = expected_updates.pop_front();
          if (out_ch.weight_out !== exp_upd.weight)
            note_error($sformatf("result %0d weight expected %h actual %h",
                                 updates_checked, exp_upd.weight, out_ch.weight_out));
          if (out_ch.velocity_out !== exp_upd.velocity)
            note_error($sformatf("result %0d velocity expected %h actual %h",
                                 updates_checked, exp_upd.velocity, out_ch.velocity_out));
        end
        updates_checked++;
      end
      out_ch.ready <= !take_break();
    end
  end

  // stimulus sequence
  initial begin
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_wdata         = '0;
    in_ch.valid       = 1'b0;
    in_ch.weight_in   = '0;
    in_ch.gradient_in = '0;
    in_ch.velocity_in = '0;
    out_ch.ready      = 1'b0;
    lr_cfg            = sgdm_pkg::LR_RESET;
    mu_cfg            = sgdm_pkg::MOMENTUM_RESET;
    damp_cfg          = sgdm_pkg::DAMPENING_RESET;
    decay_cfg         = sgdm_pkg::DECAY_RESET;
    nesterov_cfg      = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // register defaults straight out of reset
    queue_corners();
    queue_random(RANDOM_PER_PHASE);
    wait_idle();

    // fixed settings, extremes among them; one phase runs with no idling
    for (int p = 0; p < 7; p++) begin
      steady_run = (p == 3);
      apply_settings(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2],
                     phase_cfg[p][3], phase_cfg[p][4]);
      if (p == 0) queue_corners();
      queue_random(RANDOM_PER_PHASE);
      wait_idle();
    end
    steady_run = 1'b0;

    // random settings
    for (int p = 0; p < 4; p++) begin
      apply_settings(pick_coef(), pick_coef(), pick_coef(), pick_coef(),
                     sgdm_pkg::cfg_data_t'($urandom_range(0, 1)));
      queue_random(RANDOM_PER_PHASE);
      wait_idle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (expected_updates.size() != 0)
      note_error($sformatf("%0d results never arrived", expected_updates.size()));

    $display("sent %0d elements under %0d register settings plus reset defaults",
             elems_sent, settings_applied);
    $display("checked %0d results, %0d mismatches", updates_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_sgd_momentum_update_unit: PASS");
    end else begin
      $display("tb_sgd_momentum_update_unit: FAIL");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2_000_000;
    $display("timeout after %0d results", updates_checked);
    $display("tb_sgd_momentum_update_unit: FAIL");
    $finish;
  end

endmodule
